FILE: src/ptwc_pkg.sv
// ----------------------------------------------------------------------------
// ptwc_pkg: shared types and constants
// Payload structs, opcodes and sizes of the prefix tree word counter.
// ----------------------------------------------------------------------------
package ptwc_pkg;

    localparam int NODES    = 4096;
    localparam int ALPHABET = 26;
    localparam int MAX_LEN  = 32;
    localparam int COUNT_W  = 16;

    localparam int NODE_W  = $clog2(NODES);
    localparam int LINK_AW = $clog2(NODES * ALPHABET);
    localparam int LET_W   = 5;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int BUF_AW  = $clog2(MAX_LEN);
    localparam int ZK_W    = $clog2(ALPHABET);

    localparam logic [NODE_W-1:0]  ROOT = NODE_W'(1);
    localparam logic [COUNT_W-1:0] CMAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_EXACT  = 3'd1,
        OP_PREFIX = 3'd2,
        OP_ERASE  = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0] opcode;
        logic [4:0] letter;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [15:0] count;
        logic [1:0]  status;
    } t_out;

endpackage

FILE: src/prefix_tree_word_counter.sv
// ----------------------------------------------------------------------------
// prefix_tree_word_counter: dictionary of words in a prefix tree
// Counts inserted words and prefixes, erases and clears, one letter per beat.
// ----------------------------------------------------------------------------
// Input channel (i_valid, o_stall, i_data) carries one letter per beat with
// an opcode and a last mark. Letters before the last are buffered, one per
// beat while idle. The beat with the last mark starts a walk of the buffered
// word by a small sequencer over one link ram and two count rams; each
// letter passes a buffer read, a link read, a count read and an update.
// Queries walk the word once. An insert walks once to check for room and
// again to apply, clearing the link row of each new node; an erase of a
// present word also walks twice. A too-long word or unknown opcode is
// answered without a walk; a clear rewrites the root link row. One result
// beat (o_valid, i_stall, o_data) comes per word or clear; o_stall is high
// while a word is being worked. After reset the root link row is cleared
// with o_stall high. A result waits in the output register while the
// receiver stalls; further letters are taken meanwhile, and the next
// result waits for it.
// ----------------------------------------------------------------------------
module prefix_tree_word_counter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ptwc_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output ptwc_pkg::t_out  o_data
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_BUF, S_LNK, S_CHK, S_CNT, S_ZERO, S_DEC, S_END, S_OUT
    } t_state;

    t_state r_state;

    logic [ptwc_pkg::LEN_W-1:0]   r_len, r_wlen, r_i, r_need;
    logic                         r_long, r_apply, r_missing, r_full, r_clr_res;
    logic [2:0]                   r_op;
    logic [ptwc_pkg::NODE_W-1:0]  r_cur, r_last;
    logic [ptwc_pkg::LINK_AW-1:0] r_at;
    logic [ptwc_pkg::COUNT_W-1:0] r_end, r_res_cnt;
    logic [1:0]                   r_res_st;
    logic [ptwc_pkg::ZK_W-1:0]    r_zk;
    logic                         r_ov;
    ptwc_pkg::t_out               r_odata;
    logic [ptwc_pkg::LET_W-1:0]   r_buf [ptwc_pkg::MAX_LEN];
    logic [ptwc_pkg::LET_W-1:0]   r_buf_q;

    logic                         lk_we;
    logic [ptwc_pkg::LINK_AW-1:0] lk_wa, lk_ra;
    logic [ptwc_pkg::NODE_W-1:0]  lk_wd, lk_q;
    logic                         ps_we, en_we;
    logic [ptwc_pkg::NODE_W-1:0]  ps_wa, en_wa;
    logic [ptwc_pkg::COUNT_W-1:0] ps_wd, en_wd, ps_q, en_q;

    logic                         acc;
    logic [ptwc_pkg::LET_W-1:0]   let_sat;
    logic [ptwc_pkg::LEN_W-1:0]   i_nx;
    logic                         done;
    logic [ptwc_pkg::LINK_AW-1:0] at_calc, row_base;
    logic [ptwc_pkg::NODE_W:0]    need_sum;
    logic                         full;

    assign acc      = i_valid && !o_stall;
    assign let_sat  = (i_data.letter >= ptwc_pkg::LET_W'(ptwc_pkg::ALPHABET))
                      ? ptwc_pkg::LET_W'(ptwc_pkg::ALPHABET - 1) : i_data.letter;
    assign i_nx     = r_i + 1'b1;
    assign done     = (i_nx == r_wlen);
    assign row_base = ptwc_pkg::LINK_AW'(r_cur) * ptwc_pkg::LINK_AW'(ptwc_pkg::ALPHABET);
    assign at_calc  = row_base + ptwc_pkg::LINK_AW'(r_buf_q);
    assign need_sum = {1'b0, r_last} + (ptwc_pkg::NODE_W + 1)'(r_need);
    assign full     = r_full || (!r_missing && (r_end == ptwc_pkg::CMAX))
                      || (need_sum > (ptwc_pkg::NODE_W + 1)'(ptwc_pkg::NODES - 1));

    // memory port control
    always_comb begin
        lk_we = 1'b0;
        lk_wa = r_at;
        lk_wd = '0;
        lk_ra = at_calc;
        ps_we = 1'b0;
        ps_wa = r_cur;
        ps_wd = ps_q + 1'b1;
        en_we = 1'b0;
        en_wa = r_cur;
        en_wd = (r_op == ptwc_pkg::OP_ERASE) ? r_end - 1'b1 : r_end + 1'b1;
        unique case (r_state)
            S_CLR: begin
                lk_we = 1'b1;
                lk_wa = ptwc_pkg::LINK_AW'(ptwc_pkg::ROOT)
                        * ptwc_pkg::LINK_AW'(ptwc_pkg::ALPHABET)
                        + ptwc_pkg::LINK_AW'(r_zk);
            end
            S_CHK: begin
                if (r_apply && lk_q == '0) begin
                    lk_we = 1'b1;
                    lk_wd = r_last + 1'b1;
                end
            end
            S_ZERO: begin
                lk_we = 1'b1;
                lk_wa = row_base + ptwc_pkg::LINK_AW'(r_zk);
                // new node starts with pass one and end zero
                if (r_zk == ptwc_pkg::ZK_W'(ptwc_pkg::ALPHABET - 1)) begin
                    ps_we = 1'b1;
                    ps_wd = ptwc_pkg::COUNT_W'(1);
                    en_we = 1'b1;
                    en_wd = '0;
                end
            end
            S_CNT: begin
                if (r_apply) begin
                    ps_we = 1'b1;
                    if (r_op == ptwc_pkg::OP_ERASE) begin
                        ps_wd = ps_q - 1'b1;
                        // pass count drops to zero: cut the link
                        if (ps_q == ptwc_pkg::COUNT_W'(1)) begin
                            lk_we = 1'b1;
                        end
                    end
                end
            end
            S_END: en_we = 1'b1;
            default: begin
            end
        endcase
    end

    ptwc_ram #(.DEPTH(ptwc_pkg::NODES * ptwc_pkg::ALPHABET), .WIDTH(ptwc_pkg::NODE_W))
    u_links (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_wa), .i_wdata(lk_wd),
        .i_raddr(lk_ra), .o_rdata(lk_q)
    );

    ptwc_ram #(.DEPTH(ptwc_pkg::NODES), .WIDTH(ptwc_pkg::COUNT_W)) u_pass (
        .i_clk(i_clk), .i_we(ps_we), .i_waddr(ps_wa), .i_wdata(ps_wd),
        .i_raddr(lk_q), .o_rdata(ps_q)
    );

    ptwc_ram #(.DEPTH(ptwc_pkg::NODES), .WIDTH(ptwc_pkg::COUNT_W)) u_end (
        .i_clk(i_clk), .i_we(en_we), .i_waddr(en_wa), .i_wdata(en_wd),
        .i_raddr(lk_q), .o_rdata(en_q)
    );

    // word buffer
    always_ff @(posedge i_clk) begin
        if (acc && i_data.opcode != ptwc_pkg::OP_CLEAR
            && r_len < ptwc_pkg::LEN_W'(ptwc_pkg::MAX_LEN)) begin
            r_buf[r_len[ptwc_pkg::BUF_AW-1:0]] <= let_sat;
        end
        r_buf_q <= r_buf[r_i[ptwc_pkg::BUF_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_res <= 1'b0;
            r_zk      <= '0;
            r_len     <= '0;
            r_long    <= 1'b0;
            r_last    <= ptwc_pkg::ROOT;
            r_ov      <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_zk <= r_zk + 1'b1;
                    if (r_zk == ptwc_pkg::ZK_W'(ptwc_pkg::ALPHABET - 1)) begin
                        r_res_cnt <= '0;
                        r_res_st  <= ptwc_pkg::ST_DONE;
                        r_state   <= r_clr_res ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        if (i_data.opcode == ptwc_pkg::OP_CLEAR) begin
                            r_len     <= '0;
                            r_long    <= 1'b0;
                            r_last    <= ptwc_pkg::ROOT;
                            r_zk      <= '0;
                            r_clr_res <= 1'b1;
                            r_state   <= S_CLR;
                        end else if (!i_data.last) begin
                            if (r_len < ptwc_pkg::LEN_W'(ptwc_pkg::MAX_LEN)) begin
                                r_len <= r_len + 1'b1;
                            end else begin
                                r_long <= 1'b1;
                            end
                        end else begin
                            r_len     <= '0;
                            r_long    <= 1'b0;
                            r_wlen    <= (r_len == ptwc_pkg::LEN_W'(ptwc_pkg::MAX_LEN))
                                         ? r_len : r_len + 1'b1;
                            r_op      <= i_data.opcode;
                            r_apply   <= 1'b0;
                            r_i       <= '0;
                            r_cur     <= ptwc_pkg::ROOT;
                            r_full    <= 1'b0;
                            r_missing <= 1'b0;
                            r_need    <= '0;
                            r_end     <= '0;
                            r_res_cnt <= '0;
                            r_res_st  <= (r_long
                                          || r_len == ptwc_pkg::LEN_W'(ptwc_pkg::MAX_LEN))
                                         ? ptwc_pkg::ST_LONG : ptwc_pkg::ST_DONE;
                            if (r_long || r_len == ptwc_pkg::LEN_W'(ptwc_pkg::MAX_LEN)) begin
                                r_state <= S_OUT;
                            end else if (i_data.opcode == ptwc_pkg::OP_INSERT
                                         || i_data.opcode == ptwc_pkg::OP_EXACT
                                         || i_data.opcode == ptwc_pkg::OP_PREFIX
                                         || i_data.opcode == ptwc_pkg::OP_ERASE) begin
                                r_state <= S_BUF;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                    end
                end
                S_BUF: r_state <= S_LNK;
                S_LNK: begin
                    r_at    <= at_calc;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (!r_apply) begin
                        if (lk_q == '0) begin
                            if (r_op == ptwc_pkg::OP_INSERT) begin
                                r_missing <= 1'b1;
                                r_need    <= r_wlen - r_i;
                                r_state   <= S_DEC;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_cur   <= lk_q;
                            r_state <= S_CNT;
                        end
                    end else if (lk_q == '0) begin
                        r_last  <= r_last + 1'b1;
                        r_cur   <= r_last + 1'b1;
                        r_zk    <= '0;
                        r_state <= S_ZERO;
                    end else begin
                        r_cur   <= lk_q;
                        r_state <= S_CNT;
                    end
                end
                S_CNT: begin
                    r_end <= en_q;
                    if (!r_apply) begin
                        priority case (r_op)
                            ptwc_pkg::OP_INSERT: begin
                                if (ps_q == ptwc_pkg::CMAX) begin
                                    r_full <= 1'b1;
                                end
                                r_i     <= i_nx;
                                r_state <= done ? S_DEC : S_BUF;
                            end
                            ptwc_pkg::OP_EXACT, ptwc_pkg::OP_PREFIX: begin
                                r_i <= i_nx;
                                if (done) begin
                                    r_res_cnt <= (r_op == ptwc_pkg::OP_EXACT) ? en_q : ps_q;
                                    r_state   <= S_OUT;
                                end else begin
                                    r_state <= S_BUF;
                                end
                            end
                            default: begin
                                if (!done) begin
                                    r_i     <= i_nx;
                                    r_state <= S_BUF;
                                end else if (en_q == '0) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_apply <= 1'b1;
                                    r_i     <= '0;
                                    r_cur   <= ptwc_pkg::ROOT;
                                    r_state <= S_BUF;
                                end
                            end
                        endcase
                    end else if (r_op == ptwc_pkg::OP_ERASE
                                 && ps_q == ptwc_pkg::COUNT_W'(1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= i_nx;
                        r_state <= done ? S_END : S_BUF;
                    end
                end
                S_ZERO: begin
                    r_zk <= r_zk + 1'b1;
                    if (r_zk == ptwc_pkg::ZK_W'(ptwc_pkg::ALPHABET - 1)) begin
                        r_end   <= '0;
                        r_i     <= i_nx;
                        r_state <= done ? S_END : S_BUF;
                    end
                end
                S_DEC: begin
                    if (full) begin
                        r_res_st <= ptwc_pkg::ST_FULL;
                        r_state  <= S_OUT;
                    end else begin
                        r_apply <= 1'b1;
                        r_i     <= '0;
                        r_cur   <= ptwc_pkg::ROOT;
                        r_state <= S_BUF;
                    end
                end
                S_END: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_odata.count  <= r_res_cnt;
                        r_odata.status <= r_res_st;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_odata;

endmodule

FILE: src/ptwc_ram.sv
// ----------------------------------------------------------------------------
// ptwc_ram: simple dual port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptwc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

FILE: src/ptwc_checker.sv
// ----------------------------------------------------------------------------
// ptwc_checker: port assertions
// Checks result beats of the prefix tree word counter over time.
// ----------------------------------------------------------------------------
module ptwc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input ptwc_pkg::t_out o_data
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result beat changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status <= ptwc_pkg::ST_LONG)
        else $error("bad status code");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ptwc_pkg::ST_DONE |-> o_data.count == '0)
        else $error("count given with failing status");

endmodule

bind prefix_tree_word_counter ptwc_checker u_ptwc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid),
    .i_stall(i_stall), .o_data(o_data)
);
